@@ sv/smeu_pkg.sv @@
// Shared types, constants and opcode definitions for the scalar MIPS execute unit.
package smeu_pkg;

  localparam int DMEM_BYTES = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int DMEM_ROWS  = DMEM_BYTES / 4;
  localparam int ROW_AW     = DMEM_AW - 2;
  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int PC_W       = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

  // Primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_BLEZ    = 6'h06;
  localparam logic [5:0] OPC_BGTZ    = 6'h07;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_BREAK = 6'h0D;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  // Internal execute operations
  localparam logic [4:0] EX_NONE = 5'd0;
  localparam logic [4:0] EX_SLL  = 5'd1;
  localparam logic [4:0] EX_SRL  = 5'd2;
  localparam logic [4:0] EX_SRA  = 5'd3;
  localparam logic [4:0] EX_ADD  = 5'd4;
  localparam logic [4:0] EX_SUB  = 5'd5;
  localparam logic [4:0] EX_AND  = 5'd6;
  localparam logic [4:0] EX_OR   = 5'd7;
  localparam logic [4:0] EX_XOR  = 5'd8;
  localparam logic [4:0] EX_NOR  = 5'd9;
  localparam logic [4:0] EX_SLT  = 5'd10;
  localparam logic [4:0] EX_SLTU = 5'd11;
  localparam logic [4:0] EX_LUI  = 5'd12;
  localparam logic [4:0] EX_LOAD = 5'd13;
  localparam logic [4:0] EX_STORE = 5'd14;
  localparam logic [4:0] EX_BLTZ = 5'd15;
  localparam logic [4:0] EX_BGEZ = 5'd16;
  localparam logic [4:0] EX_BEQ  = 5'd17;
  localparam logic [4:0] EX_BNE  = 5'd18;
  localparam logic [4:0] EX_BLEZ = 5'd19;
  localparam logic [4:0] EX_BGTZ = 5'd20;
  localparam logic [4:0] EX_J    = 5'd21;
  localparam logic [4:0] EX_JR   = 5'd22;

  // Access size, stored as byte count minus one
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd3;

  typedef struct packed {
    logic [31:0]     instruction_word;
    logic [PC_W-1:0] current_pc;
  } req_t;

  typedef struct packed {
    logic            dest_valid;
    logic [4:0]      dest_index;
    logic [31:0]     dest_value;
    logic            branch_taken;
    logic [PC_W-1:0] branch_target;
    logic            break_hit;
    logic            unsupported;
  } rsp_t;

  typedef struct packed {
    logic [4:0]        op;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] dest;
    logic              use_imm;
    logic [31:0]       imm;
    logic              shamt_reg;
    logic [4:0]        sa;
    logic              link_wr;
    logic [PC_W-1:0]   link;
    logic [PC_W-1:0]   btgt;
    logic [PC_W-1:0]   jtgt;
    logic [1:0]        mem_last;
    logic              load_signed;
    logic              brk;
    logic              unsup;
  } uop_t;

endpackage

@@ sv/smeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/smeu_front.sv @@
// Front end: accept requests, decode them into micro-ops, and queue them.
module smeu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  smeu_pkg::req_t      req,
  input  logic                busy,
  output logic                head_valid,
  output smeu_pkg::uop_t      head,
  input  logic                pop
);

  smeu_pkg::uop_t                     dec;
  smeu_pkg::uop_t                     queue [smeu_pkg::QUEUE_DEPTH];
  logic [smeu_pkg::QUEUE_AW-1:0]      wptr;
  logic [smeu_pkg::QUEUE_AW-1:0]      rptr;
  logic [smeu_pkg::QUEUE_CW-1:0]      count;
  logic                               push;
  logic [31:0]                        w;
  logic [31:0]                        sext_imm;
  logic [smeu_pkg::PC_W-1:0]          pc;

  assign w        = req.instruction_word;
  assign pc       = req.current_pc;
  assign sext_imm = {{16{w[15]}}, w[15:0]};

  always_comb begin
    dec             = '0;
    dec.rs          = w[25:21];
    dec.rt          = w[20:16];
    dec.sa          = w[10:6];
    dec.link        = pc + smeu_pkg::PC_W'(8);
    dec.btgt        = pc + smeu_pkg::PC_W'(4) + {w[smeu_pkg::PC_W-3:0], 2'b00};
    dec.jtgt        = {w[9:0], 2'b00};
    dec.imm         = sext_imm;
    unique case (w[31:26])
      smeu_pkg::OPC_SPECIAL: begin
        dec.dest = w[15:11];
        unique case (w[5:0])
          smeu_pkg::FN_SLL:  dec.op = smeu_pkg::EX_SLL;
          smeu_pkg::FN_SRL:  dec.op = smeu_pkg::EX_SRL;
          smeu_pkg::FN_SRA:  dec.op = smeu_pkg::EX_SRA;
          smeu_pkg::FN_SLLV: begin
            dec.op = smeu_pkg::EX_SLL;
            dec.shamt_reg = 1'b1;
          end
          smeu_pkg::FN_SRLV: begin
            dec.op = smeu_pkg::EX_SRL;
            dec.shamt_reg = 1'b1;
          end
          smeu_pkg::FN_SRAV: begin
            dec.op = smeu_pkg::EX_SRA;
            dec.shamt_reg = 1'b1;
          end
          smeu_pkg::FN_JR: begin
            dec.op   = smeu_pkg::EX_JR;
            dec.dest = '0;
          end
          smeu_pkg::FN_JALR: begin
            dec.op      = smeu_pkg::EX_JR;
            dec.link_wr = 1'b1;
          end
          smeu_pkg::FN_BREAK: begin
            dec.brk  = 1'b1;
            dec.dest = '0;
          end
          smeu_pkg::FN_ADD, smeu_pkg::FN_ADDU: dec.op = smeu_pkg::EX_ADD;
          smeu_pkg::FN_SUB, smeu_pkg::FN_SUBU: dec.op = smeu_pkg::EX_SUB;
          smeu_pkg::FN_AND:  dec.op = smeu_pkg::EX_AND;
          smeu_pkg::FN_OR:   dec.op = smeu_pkg::EX_OR;
          smeu_pkg::FN_XOR:  dec.op = smeu_pkg::EX_XOR;
          smeu_pkg::FN_NOR:  dec.op = smeu_pkg::EX_NOR;
          smeu_pkg::FN_SLT:  dec.op = smeu_pkg::EX_SLT;
          smeu_pkg::FN_SLTU: dec.op = smeu_pkg::EX_SLTU;
          default: begin
            dec.unsup = 1'b1;
            dec.dest  = '0;
          end
        endcase
      end
      smeu_pkg::OPC_REGIMM: begin
        unique case (w[20:16])
          smeu_pkg::RI_BLTZ: dec.op = smeu_pkg::EX_BLTZ;
          smeu_pkg::RI_BGEZ: dec.op = smeu_pkg::EX_BGEZ;
          smeu_pkg::RI_BLTZAL: begin
            dec.op      = smeu_pkg::EX_BLTZ;
            dec.link_wr = 1'b1;
            dec.dest    = 5'd31;
          end
          smeu_pkg::RI_BGEZAL: begin
            dec.op      = smeu_pkg::EX_BGEZ;
            dec.link_wr = 1'b1;
            dec.dest    = 5'd31;
          end
          default: dec.unsup = 1'b1;
        endcase
      end
      smeu_pkg::OPC_J:    dec.op = smeu_pkg::EX_J;
      smeu_pkg::OPC_JAL: begin
        dec.op      = smeu_pkg::EX_J;
        dec.link_wr = 1'b1;
        dec.dest    = 5'd31;
      end
      smeu_pkg::OPC_BEQ:  dec.op = smeu_pkg::EX_BEQ;
      smeu_pkg::OPC_BNE:  dec.op = smeu_pkg::EX_BNE;
      smeu_pkg::OPC_BLEZ: dec.op = smeu_pkg::EX_BLEZ;
      smeu_pkg::OPC_BGTZ: dec.op = smeu_pkg::EX_BGTZ;
      smeu_pkg::OPC_ADDI, smeu_pkg::OPC_ADDIU: begin
        dec.op = smeu_pkg::EX_ADD;
        dec.use_imm = 1'b1;
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_SLTI: begin
        dec.op = smeu_pkg::EX_SLT;
        dec.use_imm = 1'b1;
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_SLTIU: begin
        dec.op = smeu_pkg::EX_SLTU;
        dec.use_imm = 1'b1;
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_ANDI: begin
        dec.op = smeu_pkg::EX_AND;
        dec.use_imm = 1'b1;
        dec.imm = {16'h0000, w[15:0]};
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_ORI: begin
        dec.op = smeu_pkg::EX_OR;
        dec.use_imm = 1'b1;
        dec.imm = {16'h0000, w[15:0]};
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_XORI: begin
        dec.op = smeu_pkg::EX_XOR;
        dec.use_imm = 1'b1;
        dec.imm = {16'h0000, w[15:0]};
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_LUI: begin
        dec.op = smeu_pkg::EX_LUI;
        dec.imm = {w[15:0], 16'h0000};
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_LB, smeu_pkg::OPC_LBU: begin
        dec.op = smeu_pkg::EX_LOAD;
        dec.mem_last = smeu_pkg::SZ_BYTE;
        dec.load_signed = (w[31:26] == smeu_pkg::OPC_LB);
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_LH, smeu_pkg::OPC_LHU: begin
        dec.op = smeu_pkg::EX_LOAD;
        dec.mem_last = smeu_pkg::SZ_HALF;
        dec.load_signed = (w[31:26] == smeu_pkg::OPC_LH);
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_LW: begin
        dec.op = smeu_pkg::EX_LOAD;
        dec.mem_last = smeu_pkg::SZ_WORD;
        dec.dest = w[20:16];
      end
      smeu_pkg::OPC_SB: begin
        dec.op = smeu_pkg::EX_STORE;
        dec.mem_last = smeu_pkg::SZ_BYTE;
      end
      smeu_pkg::OPC_SH: begin
        dec.op = smeu_pkg::EX_STORE;
        dec.mem_last = smeu_pkg::SZ_HALF;
      end
      smeu_pkg::OPC_SW: begin
        dec.op = smeu_pkg::EX_STORE;
        dec.mem_last = smeu_pkg::SZ_WORD;
      end
      default: dec.unsup = 1'b1;
    endcase
  end

  assign req_stall  = busy || (count == smeu_pkg::QUEUE_CW'(smeu_pkg::QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign head       = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + smeu_pkg::QUEUE_CW'(push) - smeu_pkg::QUEUE_CW'(pop);
    end
  end

endmodule

@@ sv/smeu_back.sv @@
// Back end: register read, execute and memory access, writeback and result register.
module smeu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  smeu_pkg::uop_t      head,
  output logic                pop,
  output logic                busy,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output smeu_pkg::rsp_t      rsp
);

  // Clearing pass over the data memory rows
  logic                          clr;
  logic [smeu_pkg::ROW_AW-1:0]   clr_row;

  logic                          advance;

  // Execute stage
  logic                          e2_valid;
  smeu_pkg::uop_t                e2;

  // Result stage
  logic                          e3_valid;
  logic [smeu_pkg::REG_AW-1:0]   e3_dest;
  logic [31:0]                   e3_value;
  logic                          e3_taken;
  logic [smeu_pkg::PC_W-1:0]     e3_target;
  logic                          e3_brk;
  logic                          e3_unsup;
  logic                          e3_load;
  logic [1:0]                    e3_ea_lo;
  logic [1:0]                    e3_mem_last;
  logic                          e3_load_signed;
  logic [31:0]                   e3_final;
  logic                          e3_wr;

  // Last register write, for the read that raced it
  logic                          lw_valid;
  logic [smeu_pkg::REG_AW-1:0]   lw_idx;
  logic [31:0]                   lw_val;

  logic [smeu_pkg::REG_COUNT-1:0] rf_vld;
  logic [31:0]                   rf_qa;
  logic [31:0]                   rf_qb;
  logic [31:0]                   a;
  logic [31:0]                   b;
  logic [31:0]                   bo;
  logic [4:0]                    shamt;
  logic [31:0]                   ex_value;
  logic                          ex_taken;
  logic [smeu_pkg::PC_W-1:0]     ex_target;
  logic [31:0]                   ea;

  logic [7:0]                    lane_q [4];
  logic                          lane_we [4];
  logic                          lane_re;
  logic [smeu_pkg::ROW_AW-1:0]   lane_row [4];
  logic [smeu_pkg::ROW_AW-1:0]   lane_waddr [4];
  logic [7:0]                    lane_wd [4];
  logic [7:0]                    ld_byte [4];
  logic [31:0]                   ld_val;

  assign busy    = clr;
  assign advance = !e3_valid || !rsp_stall;
  assign pop     = advance && !clr && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr     <= 1'b1;
      clr_row <= '0;
    end else if (clr) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == smeu_pkg::ROW_AW'(smeu_pkg::DMEM_ROWS - 1)) begin
        clr <= 1'b0;
      end
    end
  end

  // Register file: two read copies, both written at retire
  smeu_ram #(.WIDTH(32), .DEPTH(smeu_pkg::REG_COUNT)) u_rf_a (
    .clk(clk), .we(advance && e3_valid && e3_wr), .waddr(e3_dest), .wdata(e3_final),
    .re(pop), .raddr(head.rs), .rdata(rf_qa)
  );
  smeu_ram #(.WIDTH(32), .DEPTH(smeu_pkg::REG_COUNT)) u_rf_b (
    .clk(clk), .we(advance && e3_valid && e3_wr), .waddr(e3_dest), .wdata(e3_final),
    .re(pop), .raddr(head.rt), .rdata(rf_qb)
  );

  // Operand read with bypass: result stage first, then last write, then the file
  always_comb begin
    if (e2.rs == '0) begin
      a = '0;
    end else if (e3_valid && e3_wr && e3_dest == e2.rs) begin
      a = e3_final;
    end else if (lw_valid && lw_idx == e2.rs) begin
      a = lw_val;
    end else if (rf_vld[e2.rs]) begin
      a = rf_qa;
    end else begin
      a = '0;
    end
    if (e2.rt == '0) begin
      b = '0;
    end else if (e3_valid && e3_wr && e3_dest == e2.rt) begin
      b = e3_final;
    end else if (lw_valid && lw_idx == e2.rt) begin
      b = lw_val;
    end else if (rf_vld[e2.rt]) begin
      b = rf_qb;
    end else begin
      b = '0;
    end
  end

  assign bo    = e2.use_imm ? e2.imm : b;
  assign shamt = e2.shamt_reg ? a[4:0] : e2.sa;
  assign ea    = a + e2.imm;

  always_comb begin
    case (e2.op)
      smeu_pkg::EX_SLL:  ex_value = b << shamt;
      smeu_pkg::EX_SRL:  ex_value = b >> shamt;
      smeu_pkg::EX_SRA:  ex_value = $unsigned($signed(b) >>> shamt);
      smeu_pkg::EX_ADD:  ex_value = a + bo;
      smeu_pkg::EX_SUB:  ex_value = a - b;
      smeu_pkg::EX_AND:  ex_value = a & bo;
      smeu_pkg::EX_OR:   ex_value = a | bo;
      smeu_pkg::EX_XOR:  ex_value = a ^ bo;
      smeu_pkg::EX_NOR:  ex_value = ~(a | b);
      smeu_pkg::EX_SLT:  ex_value = {31'd0, $signed(a) < $signed(bo)};
      smeu_pkg::EX_SLTU: ex_value = {31'd0, a < bo};
      smeu_pkg::EX_LUI:  ex_value = e2.imm;
      default:           ex_value = '0;
    endcase
    if (e2.link_wr) begin
      ex_value = {{(32 - smeu_pkg::PC_W){1'b0}}, e2.link};
    end
    case (e2.op)
      smeu_pkg::EX_BLTZ: ex_taken = a[31];
      smeu_pkg::EX_BGEZ: ex_taken = !a[31];
      smeu_pkg::EX_BEQ:  ex_taken = (a == b);
      smeu_pkg::EX_BNE:  ex_taken = (a != b);
      smeu_pkg::EX_BLEZ: ex_taken = a[31] || (a == '0);
      smeu_pkg::EX_BGTZ: ex_taken = !a[31] && (a != '0);
      smeu_pkg::EX_J:    ex_taken = 1'b1;
      smeu_pkg::EX_JR:   ex_taken = 1'b1;
      default:           ex_taken = 1'b0;
    endcase
    case (e2.op)
      smeu_pkg::EX_J:  ex_target = e2.jtgt;
      smeu_pkg::EX_JR: ex_target = a[smeu_pkg::PC_W-1:0];
      default:         ex_target = e2.btgt;
    endcase
    if (!ex_taken) begin
      ex_target = '0;
    end
  end

  // Data memory: four byte lanes, byte address a lives in lane a[1:0], row a >> 2
  assign lane_re = advance && e2_valid && (e2.op == smeu_pkg::EX_LOAD);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [1:0]                   k;
    logic [smeu_pkg::DMEM_AW-1:0] baddr;
    logic [1:0]                   back_k;

    assign k      = 2'(l) - ea[1:0];
    assign baddr  = ea[smeu_pkg::DMEM_AW-1:0] + smeu_pkg::DMEM_AW'(k);
    assign back_k = e2.mem_last - k;
    assign lane_row[l]   = baddr[smeu_pkg::DMEM_AW-1:2];
    assign lane_we[l]    = clr || (advance && e2_valid && (e2.op == smeu_pkg::EX_STORE)
                                   && (k <= e2.mem_last));
    assign lane_waddr[l] = clr ? clr_row : lane_row[l];
    assign lane_wd[l]    = clr ? 8'h00 : 8'(b >> {back_k, 3'b000});

    smeu_ram #(.WIDTH(8), .DEPTH(smeu_pkg::DMEM_ROWS)) u_dmem (
      .clk(clk), .we(lane_we[l]), .waddr(lane_waddr[l]), .wdata(lane_wd[l]),
      .re(lane_re), .raddr(lane_row[l]), .rdata(lane_q[l])
    );

    assign ld_byte[l] = lane_q[2'(e3_ea_lo + 2'(l))];
  end

  always_comb begin
    case (e3_mem_last)
      smeu_pkg::SZ_BYTE: ld_val = {{24{e3_load_signed && ld_byte[0][7]}}, ld_byte[0]};
      smeu_pkg::SZ_HALF: ld_val = {{16{e3_load_signed && ld_byte[0][7]}},
                                   ld_byte[0], ld_byte[1]};
      default:           ld_val = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};
    endcase
  end

  assign e3_wr    = (e3_dest != '0);
  assign e3_final = !e3_wr ? '0 : (e3_load ? ld_val : e3_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      lw_valid <= 1'b0;
      rf_vld   <= '0;
    end else if (advance) begin
      e2_valid <= pop;
      e3_valid <= e2_valid;
      lw_valid <= e3_valid && e3_wr;
      if (e3_valid && e3_wr) begin
        rf_vld[e3_dest] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e2             <= head;
      e3_dest        <= e2.dest;
      e3_value       <= ex_value;
      e3_taken       <= ex_taken;
      e3_target      <= ex_target;
      e3_brk         <= e2.brk;
      e3_unsup       <= e2.unsup;
      e3_load        <= (e2.op == smeu_pkg::EX_LOAD);
      e3_ea_lo       <= ea[1:0];
      e3_mem_last    <= e2.mem_last;
      e3_load_signed <= e2.load_signed;
      lw_idx         <= e3_dest;
      lw_val         <= e3_final;
    end
  end

  assign rsp_valid = e3_valid;
  always_comb begin
    rsp.dest_valid    = e3_wr;
    rsp.dest_index    = e3_dest;
    rsp.dest_value    = e3_final;
    rsp.branch_taken  = e3_taken;
    rsp.branch_target = e3_target;
    rsp.break_hit     = e3_brk;
    rsp.unsupported   = e3_unsup;
  end

endmodule

@@ sv/scalar_mips_execute_unit.sv @@
// Top level of the scalar MIPS execute unit: decoupled front end and back end.
//
// Executes one MIPS-like integer instruction per request and returns one result
// per request, in order. Throughput is one instruction per cycle while neither
// rsp_stall nor the reset sweep holds it: the front end decodes and queues
// requests in a two-entry queue, and the back end runs a register-read,
// execute/memory, result pipeline that advances each cycle the result register
// is free. A request passes through the queue, the execute stage register and
// the result register, which offers it. Register hazards are covered by
// forwarding, loads included, so dependent instructions also issue back to
// back. After reset the data memory is swept to zero one 4-byte row per cycle,
// over every row; req_stall stays high until the sweep is done. Loads and
// stores are big-endian with byte addresses wrapping modulo DMEM_BYTES.
module scalar_mips_execute_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  smeu_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output smeu_pkg::rsp_t rsp
);

  logic           head_valid;
  smeu_pkg::uop_t head;
  logic           pop;
  logic           busy;

  // Accept and decode; hold requests in the queue while the back end stalls
  smeu_front u_front (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .busy(busy),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  // Execute, update state, and drive the result register
  smeu_back u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head(head), .pop(pop),
    .busy(busy),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

endmodule

@@ sv/smeu_checker.sv @@
// Port-level checker for the scalar MIPS execute unit, bound to the top level.
module smeu_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input smeu_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input smeu_pkg::rsp_t rsp
);

  a_no_write_zeroed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.dest_valid |-> rsp.dest_index == '0 && rsp.dest_value == '0)
    else $error("result without write carries register data");

  a_write_not_r0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dest_valid |-> rsp.dest_index != '0)
    else $error("write reported to register zero");

  a_unsup_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.unsupported |->
      !rsp.dest_valid && !rsp.branch_taken && !rsp.break_hit)
    else $error("unsupported instruction had an effect");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind scalar_mips_execute_unit smeu_checker u_checker (
  .clk(clk), .rst(rst),
  .req_valid(req_valid), .req_stall(req_stall), .req(req),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
